// ----- rtl/core/lidar_point_colorizer_top_macros.svh -----
// Assertion macros shared by the colorizer RTL.
`ifndef LIDAR_POINT_COLORIZER_TOP_MACROS_SVH
`define LIDAR_POINT_COLORIZER_TOP_MACROS_SVH

// Checked only while the block is out of reset.
`define COLZ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("colorizer assertion failed");

// Checked during reset as well.
`define COLZ_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("colorizer reset assertion failed");

`endif

// ----- rtl/core/colz_pkg.sv -----
// Types and constants shared by the colorizer modules.
package colz_pkg;

  localparam int CFG_W    = 64;
  localparam int DIM_W    = 11;
  localparam int COEF_W   = 32;
  localparam int PROD_W   = 64;
  localparam int TERM_W   = 48;
  localparam int SUM_W    = 50;
  localparam int MAG_W    = 50;
  localparam int TDIN_W   = 144;
  localparam int TDOUT_W  = 120;
  localparam int FRAC_W   = 16;

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_POINT = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    CFG_ROW0_A = 3'd0,
    CFG_ROW0_B = 3'd1,
    CFG_ROW1_A = 3'd2,
    CFG_ROW1_B = 3'd3,
    CFG_ROW2_A = 3'd4,
    CFG_ROW2_B = 3'd5,
    CFG_WIDTH  = 3'd6,
    CFG_HEIGHT = 3'd7
  } cfg_idx_e;

  typedef logic [2:0][3:0][COEF_W-1:0] coef_mat_t;

  typedef struct packed {
    cmd_e               cmd;
    logic [9:0]         row;
    logic [9:0]         col;
    logic [7:0]         blue;
    logic [7:0]         green;
    logic [7:0]         red;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } item_t;

  typedef struct packed {
    logic advance;
  } pipe_ctrl_t;

endpackage

// ----- rtl/core/colz_proj.sv -----
// Projection through the camera matrix: product stage and sum stage.
module colz_proj
  import colz_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  pipe_ctrl_t              ctrl_i,
  input  logic                    valid_i,
  input  item_t                   item_i,
  input  coef_mat_t               coef_i,
  output logic                    valid_o,
  output item_t                   item_o,
  output logic signed [SUM_W-1:0] u_o,
  output logic signed [SUM_W-1:0] v_o,
  output logic signed [SUM_W-1:0] w_o
);

  logic                     valid1_q, valid2_q;
  item_t                    item1_q, item2_q;
  logic signed [PROD_W-1:0] prod_q [3][3];
  logic signed [COEF_W-1:0] cterm_q [3];
  logic signed [SUM_W-1:0]  sum_d [3];
  logic signed [SUM_W-1:0]  sum_q [3];
  logic                     drop1;

  // Points with negative x are discarded before any arithmetic.
  assign drop1 = (item_i.cmd == CMD_POINT) && item_i.x[31];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
    end else if (ctrl_i.advance) begin
      valid1_q <= valid_i && !drop1;
      valid2_q <= valid1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.advance) begin
      item1_q <= item_i;
      item2_q <= item1_q;
      for (int r = 0; r < 3; r++) begin
        prod_q[r][0] <= $signed(coef_i[r][0]) * item_i.x;
        prod_q[r][1] <= $signed(coef_i[r][1]) * item_i.y;
        prod_q[r][2] <= $signed(coef_i[r][2]) * item_i.z;
        cterm_q[r]   <= $signed(coef_i[r][3]);
        sum_q[r]     <= sum_d[r];
      end
    end
  end

  // Arithmetic shift gives the floor of each Q32.32 product in Q32.16.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum_d[r] = SUM_W'(TERM_W'(prod_q[r][0] >>> FRAC_W))
               + SUM_W'(TERM_W'(prod_q[r][1] >>> FRAC_W))
               + SUM_W'(TERM_W'(prod_q[r][2] >>> FRAC_W))
               + SUM_W'(cterm_q[r]);
    end
  end

  assign valid_o = valid2_q;
  assign item_o  = item2_q;
  assign u_o     = sum_q[0];
  assign v_o     = sum_q[1];
  assign w_o     = sum_q[2];

endmodule

// ----- rtl/core/colz_div.sv -----
// Sign normalisation and bit-per-stage restoring division of u and v by w.
module colz_div
  import colz_pkg::*;
#(
  parameter int QB = 10
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  pipe_ctrl_t              ctrl_i,
  input  logic                    valid_i,
  input  item_t                   item_i,
  input  logic signed [SUM_W-1:0] u_i,
  input  logic signed [SUM_W-1:0] v_i,
  input  logic signed [SUM_W-1:0] w_i,
  output logic                    valid_o,
  output item_t                   item_o,
  output logic [QB-1:0]           col_o,
  output logic [QB-1:0]           row_o
);

  localparam int N_W   = SUM_W + 1;
  localparam int REM_W = MAG_W + QB;

  logic signed [N_W-1:0] nu, nv, nd;
  logic [MAG_W-1:0]      mu, mv, md;
  logic                  drop0;

  logic              valid_q [QB+1];
  item_t             item_q  [QB+1];
  logic [MAG_W-1:0]  d_q     [QB+1];
  logic [REM_W-1:0]  remu_q  [QB+1];
  logic [REM_W-1:0]  remv_q  [QB+1];
  logic [QB-1:0]     qu_q    [QB+1];
  logic [QB-1:0]     qv_q    [QB+1];

  // A negative w flips both signs so that the divisor is positive.
  always_comb begin
    nd = w_i[SUM_W-1] ? -N_W'(w_i) : N_W'(w_i);
    nu = w_i[SUM_W-1] ? -N_W'(u_i) : N_W'(u_i);
    nv = w_i[SUM_W-1] ? -N_W'(v_i) : N_W'(v_i);
    mu = nu[MAG_W-1:0];
    mv = nv[MAG_W-1:0];
    md = nd[MAG_W-1:0];
    // A quotient of 2^QB or more lies beyond any image and is dropped here.
    drop0 = (w_i == '0) || nu[N_W-1] || nv[N_W-1]
         || ({{QB{1'b0}}, mu} >= {md, {QB{1'b0}}})
         || ({{QB{1'b0}}, mv} >= {md, {QB{1'b0}}});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
    end else if (ctrl_i.advance) begin
      valid_q[0] <= valid_i && ((item_i.cmd == CMD_PIXEL) || !drop0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.advance) begin
      item_q[0] <= item_i;
      d_q[0]    <= md;
      remu_q[0] <= REM_W'(mu);
      remv_q[0] <= REM_W'(mv);
      qu_q[0]   <= '0;
      qv_q[0]   <= '0;
    end
  end

  for (genvar s = 0; s < QB; s++) begin : g_step
    localparam int B = QB - 1 - s;
    logic [REM_W-1:0] dsh;
    logic             geu, gev;

    assign dsh = REM_W'(d_q[s]) << B;
    assign geu = remu_q[s] >= dsh;
    assign gev = remv_q[s] >= dsh;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s+1] <= 1'b0;
      end else if (ctrl_i.advance) begin
        valid_q[s+1] <= valid_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctrl_i.advance) begin
        item_q[s+1]    <= item_q[s];
        d_q[s+1]       <= d_q[s];
        remu_q[s+1]    <= geu ? remu_q[s] - dsh : remu_q[s];
        remv_q[s+1]    <= gev ? remv_q[s] - dsh : remv_q[s];
        qu_q[s+1]      <= qu_q[s] | (QB'(geu) << B);
        qv_q[s+1]      <= qv_q[s] | (QB'(gev) << B);
      end
    end
  end

  assign valid_o = valid_q[QB];
  assign item_o  = item_q[QB];
  assign col_o   = qu_q[QB];
  assign row_o   = qv_q[QB];

endmodule

// ----- rtl/core/colz_frame.sv -----
// Frame store, image bound test and the output word register.
module colz_frame
  import colz_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int QB         = 10
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  pipe_ctrl_t       ctrl_i,
  input  logic             valid_i,
  input  item_t            item_i,
  input  logic [QB-1:0]    col_i,
  input  logic [QB-1:0]    row_i,
  input  logic [DIM_W-1:0] width_i,
  input  logic [DIM_W-1:0] height_i,
  output logic             valid_o,
  output item_t            item_o,
  output logic [23:0]      rgb_o
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  logic [23:0]       mem [2**(RW+CW)];
  logic [RW+CW-1:0]  waddr, raddr;
  logic              wr_en, keep;
  logic              valid_q;
  item_t             item_q;
  logic [23:0]       rgb_q;

  // The smaller of the register and the store size bounds each coordinate.
  assign keep = (item_i.cmd == CMD_POINT)
             && (32'(col_i) < 32'(width_i))  && (32'(col_i) < MAX_WIDTH)
             && (32'(row_i) < 32'(height_i)) && (32'(row_i) < MAX_HEIGHT);

  assign wr_en = ctrl_i.advance && valid_i && (item_i.cmd == CMD_PIXEL)
              && (32'(item_i.row) < MAX_HEIGHT) && (32'(item_i.col) < MAX_WIDTH);
  assign waddr = {RW'(item_i.row), CW'(item_i.col)};
  assign raddr = {row_i[RW-1:0], col_i[CW-1:0]};

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[waddr] <= {item_i.red, item_i.green, item_i.blue};
    end
    if (ctrl_i.advance) begin
      rgb_q  <= mem[raddr];
      item_q <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.advance) begin
      valid_q <= valid_i && keep;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;
  assign rgb_o   = rgb_q;

endmodule

// ----- rtl/core/lidar_point_colorizer_top.sv -----
// Top level of the lidar point colorizer.
// The slave stream carries one command word per handshake: tuser selects a
// pixel write (0) or a point projection (1). Pixel writes fill a BGR frame
// store; points are projected through the 3x4 Q16.16 camera matrix held in
// the configuration registers, and each point that lands inside the image
// leaves on the master stream with the colour of the pixel it hits.
// Dropped points and pixel writes produce no output word.
// One word is taken every cycle unless the receiver stalls. A word passes
// through the multiplier and sum stages, a sign normalisation register,
// one division stage per quotient bit and the frame store read register.
// Pixel writes pass down the same pipeline, so a point sees every pixel
// written before it. Reset empties the pipeline, loads a zero matrix and a
// 1024 x 1024 image size; the frame store is not cleared and must be
// written before it is read. When the receiver stalls, the whole pipeline
// holds and s_axis_tready falls until the output word is taken.
// Configuration must be written only while no word is in flight, a rule
// the block leaves to the user.
module lidar_point_colorizer_top
  import colz_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // row, col, blue, green, red, x, y, z from bit 0 up; zero padded.
  input  logic [TDIN_W-1:0]  s_axis_tdata,
  // command.
  input  logic               s_axis_tuser,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // x, y, z, red, green, blue from bit 0 up.
  output logic [TDOUT_W-1:0] m_axis_tdata,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [CFG_W-1:0]   cfg_data_i
);

  localparam int QB = ($clog2(MAX_WIDTH) > $clog2(MAX_HEIGHT)) ?
                      $clog2(MAX_WIDTH) : $clog2(MAX_HEIGHT);

  logic [CFG_W-1:0] coef_q [6];
  logic [DIM_W-1:0] width_q, height_q;
  coef_mat_t        coef_mat;
  pipe_ctrl_t       ctrl;
  item_t            in_item, p_item, d_item, o_item;
  logic             p_valid, d_valid, o_valid;
  logic signed [SUM_W-1:0] u, v, w;
  logic [QB-1:0]    col, row;
  logic [23:0]      rgb;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) coef_q[i] <= '0;
      width_q  <= DIM_W'(1024);
      height_q <= DIM_W'(1024);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_ROW0_A: coef_q[0] <= cfg_data_i;
        CFG_ROW0_B: coef_q[1] <= cfg_data_i;
        CFG_ROW1_A: coef_q[2] <= cfg_data_i;
        CFG_ROW1_B: coef_q[3] <= cfg_data_i;
        CFG_ROW2_A: coef_q[4] <= cfg_data_i;
        CFG_ROW2_B: coef_q[5] <= cfg_data_i;
        CFG_WIDTH:  width_q   <= cfg_data_i[DIM_W-1:0];
        CFG_HEIGHT: height_q  <= cfg_data_i[DIM_W-1:0];
        default:    width_q   <= width_q;
      endcase
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      coef_mat[r][0] = coef_q[2*r][31:0];
      coef_mat[r][1] = coef_q[2*r][63:32];
      coef_mat[r][2] = coef_q[2*r+1][31:0];
      coef_mat[r][3] = coef_q[2*r+1][63:32];
    end
  end

  always_comb begin
    in_item.cmd   = cmd_e'(s_axis_tuser);
    in_item.row   = s_axis_tdata[9:0];
    in_item.col   = s_axis_tdata[19:10];
    in_item.blue  = s_axis_tdata[27:20];
    in_item.green = s_axis_tdata[35:28];
    in_item.red   = s_axis_tdata[43:36];
    in_item.x     = $signed(s_axis_tdata[75:44]);
    in_item.y     = $signed(s_axis_tdata[107:76]);
    in_item.z     = $signed(s_axis_tdata[139:108]);
  end

  // The pipeline moves whenever the output register is empty or being read.
  assign ctrl.advance  = !o_valid || m_axis_tready;
  assign s_axis_tready = ctrl.advance;

  colz_proj u_proj (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .valid_i (s_axis_tvalid),
    .item_i  (in_item),
    .coef_i  (coef_mat),
    .valid_o (p_valid),
    .item_o  (p_item),
    .u_o     (u),
    .v_o     (v),
    .w_o     (w)
  );

  colz_div #(.QB(QB)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .valid_i (p_valid),
    .item_i  (p_item),
    .u_i     (u),
    .v_i     (v),
    .w_i     (w),
    .valid_o (d_valid),
    .item_o  (d_item),
    .col_o   (col),
    .row_o   (row)
  );

  colz_frame #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .QB         (QB)
  ) u_frame (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .valid_i  (d_valid),
    .item_i   (d_item),
    .col_i    (col),
    .row_i    (row),
    .width_i  (width_q),
    .height_i (height_q),
    .valid_o  (o_valid),
    .item_o   (o_item),
    .rgb_o    (rgb)
  );

  assign m_axis_tvalid = o_valid;
  assign m_axis_tdata  = {rgb[7:0], rgb[15:8], rgb[23:16],
                          o_item.z, o_item.y, o_item.x};

`include "lidar_point_colorizer_top_macros.svh"

  `COLZ_ASSERT(a_kept_x_nonneg, m_axis_tvalid |-> !m_axis_tdata[31])
  `COLZ_ASSERT(a_stall_blocks_input, (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
  `COLZ_ASSERT_RST(a_reset_empties, !rst_ni |=> !m_axis_tvalid)

endmodule
